// ===== rtl/mbar_pkg.sv =====
package mbar_pkg;

  localparam int DEF_MAX_BUFFERS = 8;
  localparam int DEF_MAX_WORDS   = 256;
  localparam int AVAIL_W         = 12;
  localparam int CFG_AW          = 5;

  localparam logic [1:0] REQ_USER   = 2'd0;
  localparam logic [1:0] REQ_DMA    = 2'd1;
  localparam logic [1:0] REQ_STATUS = 2'd2;

  localparam logic [2:0] REG_ENABLED   = 3'd0;
  localparam logic [2:0] REG_IS_OUTPUT = 3'd1;
  localparam logic [2:0] REG_SILENCE   = 3'd2;
  localparam logic [2:0] REG_BCOUNT    = 3'd3;
  localparam logic [2:0] REG_WPB       = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [31:0]        data_out;
    logic [AVAIL_W-1:0] available;
    logic               flow_error;
    logic               buffer_done;
  } out_item_t;

  typedef struct packed {
    logic        enabled;
    logic        is_output;
    logic [31:0] silence_sample;
    logic [3:0]  buffer_count;
    logic [8:0]  words_per_buffer;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic fill_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic refill_pending;
    logic fill_last;
  } ctrl_sts_t;

endpackage

// ===== rtl/mbar_ctrl.sv =====
module mbar_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               restart_fill,
  input  mbar_pkg::ctrl_sts_t sts,
  output logic               busy,
  output logic               out_valid,
  output mbar_pkg::ctrl_cmd_t cmd
);
  import mbar_pkg::*;

  typedef enum logic [1:0] {S_FILL, S_IDLE, S_ACCESS, S_RESP} state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
    end else if (restart_fill) begin
      state_r <= S_FILL;
    end else begin
      case (state_r)
        S_FILL: begin
          if (sts.fill_last) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) state_r <= S_ACCESS;
        end
        S_ACCESS: begin
          state_r <= S_RESP;
        end
        S_RESP: begin
          state_r <= sts.refill_pending ? S_FILL : S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = (state_r == S_RESP);
  assign cmd.capture   = (state_r == S_IDLE) && start;
  assign cmd.execute   = (state_r == S_ACCESS);
  assign cmd.fill_step = (state_r == S_FILL);

endmodule

// ===== rtl/mbar_dp.sv =====
module mbar_dp #(
  parameter int MAX_BUFFERS = mbar_pkg::DEF_MAX_BUFFERS,
  parameter int MAX_WORDS   = mbar_pkg::DEF_MAX_WORDS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mbar_pkg::cfg_t       cfg,
  input  logic                 restart,
  input  mbar_pkg::in_item_t   in_item,
  input  mbar_pkg::ctrl_cmd_t  cmd,
  output mbar_pkg::ctrl_sts_t  sts,
  output mbar_pkg::out_item_t  out_item
);
  import mbar_pkg::*;

  localparam int BW    = (MAX_BUFFERS > 2) ? $clog2(MAX_BUFFERS) : 1;
  localparam int NW    = $clog2(MAX_BUFFERS + 1);
  localparam int OW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int TOTAL = MAX_BUFFERS * MAX_WORDS;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int RST_NB = (MAX_BUFFERS < 8) ? MAX_BUFFERS : 8;

  logic [31:0] mem [TOTAL];
  logic [31:0] mem_q_r;

  logic [1:0]             req_r;
  logic [31:0]            din_r;
  logic [BW-1:0]          playing_r, queued_r, user_r;
  logic                   chosen_r;
  logic [OW-1:0]          uoff_r, doff_r;
  logic                   flag_r;
  logic [MAX_BUFFERS-1:0] empty_r;
  logic [AW-1:0]          fill_addr_r, fill_end_r;
  logic                   refill_r, acc_r, done_r, flagout_r, dsel_r;

  logic [BW-1:0]          playing_nxt, queued_nxt, user_nxt;
  logic                   chosen_nxt;
  logic [OW-1:0]          uoff_nxt, doff_nxt;
  logic                   flag_nxt;
  logic [MAX_BUFFERS-1:0] empty_nxt;
  logic [AW-1:0]          fill_addr_nxt, fill_end_nxt;
  logic                   refill_nxt, acc_nxt, done_nxt, flagout_nxt, dsel_nxt;

  logic [NW-1:0] n;
  logic [8:0]    w;
  logic [AW-1:0] ex_addr;
  logic          ex_we;

  function automatic logic [BW-1:0] mod_n(input logic [BW-1:0] p, input logic [NW-1:0] m);
    logic [BW+NW-1:0] r;
    logic [BW+NW-1:0] d;
    r = (BW+NW)'(p);
    for (int k = BW - 1; k >= 0; k--) begin
      d = (BW+NW)'(m) << k;
      if (r >= d) r = r - d;
    end
    return BW'(r);
  endfunction

  function automatic logic [AW-1:0] slot(input logic [BW-1:0] b, input logic [OW-1:0] o);
    logic [BW-1:0] bb;
    logic [OW-1:0] oo;
    bb = (32'(b) >= MAX_BUFFERS) ? '0 : b;
    oo = (32'(o) >= MAX_WORDS) ? '0 : o;
    return AW'(AW'(bb) * AW'(MAX_WORDS) + AW'(oo));
  endfunction

  always_comb begin
    if (cfg.buffer_count < 4'd2) n = NW'(2);
    else if (32'(cfg.buffer_count) > MAX_BUFFERS) n = NW'(MAX_BUFFERS);
    else n = NW'(cfg.buffer_count);
    if (cfg.words_per_buffer == 9'd0) w = 9'd1;
    else if (32'(cfg.words_per_buffer) > MAX_WORDS) w = 9'(MAX_WORDS);
    else w = cfg.words_per_buffer;
  end

  function automatic logic [BW-1:0] adv(input logic [BW-1:0] p, input logic [NW-1:0] m);
    return (32'(p) + 1 >= 32'(m)) ? '0 : BW'(p + 1'b1);
  endfunction

  // Start buffer for the first user access.
  logic [NW:0]   pick_s;
  logic [BW-1:0] pick;
  always_comb begin
    if (cfg.is_output) pick_s = (NW+1)'(mod_n(queued_r, n)) + (NW+1)'(2);
    else pick_s = (NW+1)'(mod_n(playing_r, n)) + (NW+1)'(n) - (NW+1)'(1);
    if (pick_s >= (NW+1)'(n)) pick_s = pick_s - (NW+1)'(n);
    pick = BW'(pick_s);
  end

  always_comb begin
    logic [BW-1:0] ub, cur, nq;
    logic [OW-1:0] uo;
    logic          rdy, ok;
    playing_nxt   = playing_r;
    queued_nxt    = queued_r;
    user_nxt      = user_r;
    chosen_nxt    = chosen_r;
    uoff_nxt      = uoff_r;
    doff_nxt      = doff_r;
    flag_nxt      = flag_r;
    empty_nxt     = empty_r;
    fill_addr_nxt = fill_addr_r;
    fill_end_nxt  = fill_end_r;
    refill_nxt    = 1'b0;
    acc_nxt       = 1'b0;
    done_nxt      = 1'b0;
    dsel_nxt      = 1'b0;
    ex_addr       = '0;
    ex_we         = 1'b0;
    ub  = chosen_r ? user_r : pick;
    uo  = chosen_r ? uoff_r : '0;
    cur = (32'(playing_r) < MAX_BUFFERS) ? playing_r : '0;
    nq  = (32'(queued_r) < MAX_BUFFERS) ? queued_r : '0;
    rdy = 1'b0;
    ok  = 1'b0;
    case (req_r)
      REQ_USER: begin
        if (cfg.enabled) begin
          chosen_nxt = 1'b1;
          user_nxt   = ub;
          uoff_nxt   = uo;
          if (32'(ub) < MAX_BUFFERS) rdy = cfg.is_output ? empty_r[ub] : !empty_r[ub];
          ok = rdy && (ub != playing_r);
          if (ok) begin
            ex_addr  = slot(ub, uo);
            ex_we    = cfg.is_output;
            dsel_nxt = !cfg.is_output;
            acc_nxt  = 1'b1;
            if (32'(uo) + 1 >= 32'(w)) begin
              empty_nxt[ub] = !cfg.is_output;
              user_nxt      = adv(ub, n);
              uoff_nxt      = '0;
            end else begin
              uoff_nxt = OW'(uo + 1'b1);
            end
          end
        end
      end
      REQ_DMA: begin
        if (cfg.enabled) begin
          ex_addr  = slot(cur, doff_r);
          ex_we    = !cfg.is_output;
          dsel_nxt = cfg.is_output;
          acc_nxt  = 1'b1;
          if (32'(doff_r) + 1 >= 32'(w)) begin
            doff_nxt = '0;
            if (cfg.is_output) begin
              empty_nxt[cur] = 1'b1;
              if (empty_nxt[nq]) flag_nxt = 1'b1;
              refill_nxt    = 1'b1;
              fill_addr_nxt = slot(cur, '0);
              fill_end_nxt  = AW'(slot(cur, '0) + AW'(w) - AW'(1));
            end else begin
              empty_nxt[cur] = 1'b0;
              if (!empty_nxt[nq]) flag_nxt = 1'b1;
            end
            playing_nxt = adv(playing_r, n);
            queued_nxt  = adv(queued_r, n);
            done_nxt    = 1'b1;
          end else begin
            doff_nxt = OW'(doff_r + 1'b1);
          end
        end
      end
      REQ_STATUS: begin
        acc_nxt  = 1'b1;
        flag_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    flagout_nxt = (req_r == REQ_STATUS) ? flag_r : flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r   <= '0;
      queued_r    <= (RST_NB == 2) ? '0 : BW'(2);
      user_r      <= BW'(RST_NB - 1);
      chosen_r    <= 1'b0;
      uoff_r      <= '0;
      doff_r      <= '0;
      flag_r      <= 1'b0;
      empty_r     <= '1;
      fill_addr_r <= '0;
      fill_end_r  <= AW'(TOTAL - 1);
      refill_r    <= 1'b0;
    end else if (restart) begin
      playing_r   <= '0;
      queued_r    <= (n == NW'(2)) ? '0 : BW'(2);
      user_r      <= BW'(n - 1'b1);
      chosen_r    <= 1'b0;
      uoff_r      <= '0;
      doff_r      <= '0;
      empty_r     <= '1;
      fill_addr_r <= '0;
      fill_end_r  <= AW'(TOTAL - 1);
      refill_r    <= 1'b0;
    end else if (cmd.execute) begin
      playing_r   <= playing_nxt;
      queued_r    <= queued_nxt;
      user_r      <= user_nxt;
      chosen_r    <= chosen_nxt;
      uoff_r      <= uoff_nxt;
      doff_r      <= doff_nxt;
      flag_r      <= flag_nxt;
      empty_r     <= empty_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_end_r  <= fill_end_nxt;
      refill_r    <= refill_nxt;
    end else if (cmd.fill_step) begin
      fill_addr_r <= AW'(fill_addr_r + 1'b1);
      refill_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_item.req_type;
      din_r <= in_item.data_in;
    end
    if (cmd.execute) begin
      acc_r     <= acc_nxt;
      done_r    <= done_nxt;
      flagout_r <= flagout_nxt;
      dsel_r    <= dsel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_step) mem[fill_addr_r] <= cfg.silence_sample;
    else if (cmd.execute && ex_we) mem[ex_addr] <= din_r;
    mem_q_r <= mem[ex_addr];
  end

  // Words the user side may still move, from the pointers after the step.
  logic [NW:0]    ring_gap;
  logic [8:0]     wpart;
  logic [NW+8:0]  prod;
  logic [NW+9:0]  sum;
  always_comb begin
    ring_gap = (NW+1)'(mod_n(playing_r, n)) + (NW+1)'(n) - (NW+1)'(mod_n(user_r, n));
    if (ring_gap >= (NW+1)'(n)) ring_gap = ring_gap - (NW+1)'(n);
    wpart = (32'(w) > 32'(uoff_r)) ? 9'(32'(w) - 32'(uoff_r)) : 9'd0;
    prod  = (NW+9)'(ring_gap) * (NW+9)'(w);
    sum   = (NW+10)'(prod) + (NW+10)'(wpart);
  end

  assign out_item.accepted    = acc_r;
  assign out_item.data_out    = dsel_r ? mem_q_r : 32'd0;
  assign out_item.available   = cfg.enabled ? sum[AVAIL_W-1:0] : '0;
  assign out_item.flow_error  = flagout_r;
  assign out_item.buffer_done = done_r;

  assign sts.refill_pending = refill_r;
  assign sts.fill_last      = (fill_addr_r == fill_end_r);

endmodule

// ===== rtl/multi_buffer_audio_ring_unit.sv =====
// Channel   | Handshake          | Payload
// ----------+--------------------+--------------------------------------------
// input     | start / busy       | in_item  (req_type, data_in)
// result    | out_valid (strobe) | out_item (accepted, data_out, available,
//           |                    |           flow_error, buffer_done)
// config    | psel/penable/pwrite| paddr, pwdata, prdata, pready (always high)
//
// An item passes through three steps: accept, execute against the sample memory, and
// the result, which the registered read port of the store sets.
// A DMA item that completes a buffer in output mode adds a silence refill of that buffer.
// After reset, and after a write of enabled in output mode, busy stays high through a
// clearing pass over all MAX_BUFFERS*MAX_WORDS words (2048 words by default).
// Reset is synchronous, active low; the receiver cannot stall, results show one cycle.
module multi_buffer_audio_ring_unit #(
  parameter int MAX_BUFFERS = mbar_pkg::DEF_MAX_BUFFERS,
  parameter int MAX_WORDS   = mbar_pkg::DEF_MAX_WORDS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  mbar_pkg::in_item_t         in_item,
  output logic                       out_valid,
  output mbar_pkg::out_item_t        out_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mbar_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import mbar_pkg::*;

  cfg_t       cfg_r;
  ctrl_cmd_t  cmd;
  ctrl_sts_t  sts;
  logic       wr;
  logic [2:0] idx;
  logic       restart;

  assign pready  = 1'b1;
  assign idx     = paddr[CFG_AW-1:2];
  assign wr      = psel && penable && pwrite;
  // Any write of enabled restarts the ring.
  assign restart = wr && (idx == REG_ENABLED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled          <= 1'b0;
      cfg_r.is_output        <= 1'b1;
      cfg_r.silence_sample   <= 32'd0;
      cfg_r.buffer_count     <= 4'd8;
      cfg_r.words_per_buffer <= 9'd256;
    end else if (wr) begin
      case (idx)
        REG_ENABLED:   cfg_r.enabled          <= pwdata[0];
        REG_IS_OUTPUT: cfg_r.is_output        <= pwdata[0];
        REG_SILENCE:   cfg_r.silence_sample   <= pwdata;
        REG_BCOUNT:    cfg_r.buffer_count     <= pwdata[3:0];
        REG_WPB:       cfg_r.words_per_buffer <= pwdata[8:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLED:   prdata = {31'd0, cfg_r.enabled};
      REG_IS_OUTPUT: prdata = {31'd0, cfg_r.is_output};
      REG_SILENCE:   prdata = cfg_r.silence_sample;
      REG_BCOUNT:    prdata = {28'd0, cfg_r.buffer_count};
      REG_WPB:       prdata = {23'd0, cfg_r.words_per_buffer};
      default:       prdata = 32'd0;
    endcase
  end

  mbar_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .restart_fill (restart && cfg_r.is_output),
    .sts          (sts),
    .busy         (busy),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  mbar_dp #(
    .MAX_BUFFERS (MAX_BUFFERS),
    .MAX_WORDS   (MAX_WORDS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .restart  (restart),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

// ===== rtl/mbar_checker.sv =====
module mbar_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input mbar_pkg::out_item_t out_item
);
  import mbar_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("no busy after accepted item");

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than a cycle");

  a_done_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.buffer_done |-> out_item.accepted)
    else $error("buffer done on refused item");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.accepted |-> out_item.data_out == 32'd0)
    else $error("data on refused item");

endmodule

bind multi_buffer_audio_ring_unit mbar_checker u_mbar_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ===== tb/multi_buffer_audio_ring_unit_test.sv =====
module multi_buffer_audio_ring_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbar_pkg::*;

  localparam int NBUF_MAX  = DEF_MAX_BUFFERS;
  localparam int NWORD_MAX = DEF_MAX_WORDS;
  localparam int WATCHDOG  = 40000;

  // Clock and the single reset at the start of the run.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Block ports, all driven to known values from time zero.
  logic              start = 1'b0;
  logic              busy;
  in_item_t          in_item = '0;
  logic              out_valid;
  out_item_t         out_item;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  multi_buffer_audio_ring_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // Shadow copy of the ring: configuration, sample memory, empty marks and
  // the pointers of both sides.
  logic [31:0] ring_words [NBUF_MAX*NWORD_MAX];
  bit          buf_empty [NBUF_MAX];
  int unsigned play_buf, queue_buf, user_buf, user_off, dma_off;
  bit          user_picked, flow_sticky;
  bit          r_enabled, r_output;
  logic [31:0] r_silence;
  logic [3:0]  r_bcount;
  logic [8:0]  r_wpb;

  // Pending input items, expected results, and run statistics.
  in_item_t    pending_items[$];
  out_item_t   expected_results[$];
  int          sender_idle_pct = 0;
  int          items_accepted = 0;
  int          results_seen = 0;
  int          buffers_completed = 0;
  int          refusals_seen = 0;
  int          error_count = 0;
  int          quiet_cycles = 0;

  function automatic void add_pending(in_item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic int unsigned ring_size();
    if (r_bcount < 2) return 2;
    if (r_bcount > NBUF_MAX) return NBUF_MAX;
    return r_bcount;
  endfunction

  function automatic int unsigned buf_words();
    if (r_wpb < 1) return 1;
    if (r_wpb > NWORD_MAX) return NWORD_MAX;
    return r_wpb;
  endfunction

  function automatic int unsigned next_buf(int unsigned p);
    return (p + 1 >= ring_size()) ? 0 : p + 1;
  endfunction

  function automatic int unsigned word_index(int unsigned b, int unsigned off);
    if (b >= NBUF_MAX) b = 0;
    if (off >= NWORD_MAX) off = 0;
    return b * NWORD_MAX + off;
  endfunction

  function automatic logic [AVAIL_W-1:0] user_room();
    int unsigned n, w, a;
    n = ring_size();
    w = buf_words();
    if (!r_enabled) return '0;
    a = (w > user_off) ? w - user_off : 0;
    a += (((play_buf % n) + n - (user_buf % n)) % n) * w;
    return a[AVAIL_W-1:0];
  endfunction

  // A write of the enable register resets the whole ring; the sticky flag stays.
  function automatic void restart_ring();
    for (int i = 0; i < NBUF_MAX; i++) buf_empty[i] = 1'b1;
    if (r_output)
      for (int i = 0; i < NBUF_MAX*NWORD_MAX; i++) ring_words[i] = r_silence;
    play_buf = 0;
    queue_buf = 2 % ring_size();
    user_buf = ring_size() - 1;
    user_picked = 1'b0;
    user_off = 0;
    dma_off = 0;
  endfunction

  function automatic void ring_reset();
    r_enabled = 1'b0;
    r_output = 1'b1;
    r_silence = '0;
    r_bcount = 4'd8;
    r_wpb = 9'd256;
    for (int i = 0; i < NBUF_MAX*NWORD_MAX; i++) ring_words[i] = '0;
    restart_ring();
    flow_sticky = 1'b0;
  endfunction

  function automatic void ring_set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_ENABLED: begin
        r_enabled = val[0];
        restart_ring();
      end
      REG_IS_OUTPUT: r_output = val[0];
      REG_SILENCE:   r_silence = val;
      REG_BCOUNT:    r_bcount = val[3:0];
      REG_WPB:       r_wpb = val[8:0];
      default: ;
    endcase
  endfunction

  // Works out the result of one accepted item and advances the shadow ring.
  function automatic out_item_t ring_step(in_item_t it);
    out_item_t   r;
    int unsigned n, w, cur, nxt;
    n = ring_size();
    w = buf_words();
    r = '0;
    if (it.req_type == REQ_USER && r_enabled) begin
      if (!user_picked) begin
        user_buf = r_output ? (queue_buf % n + 2) % n : (play_buf % n + n - 1) % n;
        user_off = 0;
        user_picked = 1'b1;
      end
      if ((r_output ? buf_empty[user_buf] : !buf_empty[user_buf]) &&
          user_buf != play_buf) begin
        if (r_output) ring_words[word_index(user_buf, user_off)] = it.data_in;
        else r.data_out = ring_words[word_index(user_buf, user_off)];
        r.accepted = 1'b1;
        if (user_off + 1 >= w) begin
          buf_empty[user_buf] = !r_output;
          user_buf = next_buf(user_buf);
          user_off = 0;
        end else begin
          user_off++;
        end
      end
    end else if (it.req_type == REQ_DMA && r_enabled) begin
      cur = play_buf < NBUF_MAX ? play_buf : 0;
      nxt = queue_buf < NBUF_MAX ? queue_buf : 0;
      if (r_output) r.data_out = ring_words[word_index(cur, dma_off)];
      else ring_words[word_index(cur, dma_off)] = it.data_in;
      r.accepted = 1'b1;
      if (dma_off + 1 >= w) begin
        dma_off = 0;
        if (r_output) begin
          for (int i = 0; i < w; i++) ring_words[word_index(cur, i)] = r_silence;
          buf_empty[cur] = 1'b1;
          if (buf_empty[nxt]) flow_sticky = 1'b1;
        end else begin
          buf_empty[cur] = 1'b0;
          if (!buf_empty[nxt]) flow_sticky = 1'b1;
        end
        play_buf = next_buf(play_buf);
        queue_buf = next_buf(queue_buf);
        r.buffer_done = 1'b1;
      end else begin
        dma_off++;
      end
    end
    r.flow_error = flow_sticky;
    if (it.req_type == REQ_STATUS) begin
      r.accepted = 1'b1;
      flow_sticky = 1'b0;
    end
    r.available = user_room();
    return r;
  endfunction

  // Driver: an item is taken at an edge with start high and busy low. The
  // prediction is made at that edge, so expectations line up with results.
  always @(posedge clk) begin : item_driver
    bit        taken;
    out_item_t pred;
    taken = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        pred = ring_step(in_item);
        expected_results = {expected_results, pred};
        void'(pending_items.pop_front());
        items_accepted++;
        taken = 1'b1;
      end
      // While an offered item waits on busy it stays on the port unchanged.
      if (taken || !start) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          start <= 1'b1;
          in_item <= pending_items[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobed result is checked field by field against the
  // oldest expectation.
  always @(posedge clk) begin : result_checker
    out_item_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result arrived with nothing expected: %p", out_item);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.buffer_done) buffers_completed++;
        if (!out_item.accepted) refusals_seen++;
        if (out_item.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_item.accepted);
          error_count++;
        end
        if (out_item.data_out !== want.data_out) begin
          $error("data_out: expected %h, got %h", want.data_out, out_item.data_out);
          error_count++;
        end
        if (out_item.available !== want.available) begin
          $error("available: expected %0d, got %0d", want.available, out_item.available);
          error_count++;
        end
        if (out_item.flow_error !== want.flow_error) begin
          $error("flow_error: expected %0d, got %0d", want.flow_error,
                 out_item.flow_error);
          error_count++;
        end
        if (out_item.buffer_done !== want.buffer_done) begin
          $error("buffer_done: expected %0d, got %0d", want.buffer_done,
                 out_item.buffer_done);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no item, result or register write taken.
  // The limit covers the full clearing pass plus a largest silence refill.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One APB write: a setup phase, then an access phase with pready high.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= CFG_AW'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    ring_set_reg(idx, val);
  endtask

  // Sets up a whole configuration, with the enable write last so that the
  // ring restarts under the new sizes.
  task automatic set_ring(bit outp, logic [31:0] sil, logic [3:0] bc,
                          logic [8:0] wpb, bit en);
    write_reg(REG_IS_OUTPUT, 32'(outp));
    write_reg(REG_SILENCE, sil);
    write_reg(REG_BCOUNT, 32'(bc));
    write_reg(REG_WPB, 32'(wpb));
    write_reg(REG_ENABLED, 32'(en));
  endtask

  // Waits until every item has been taken and answered and the block has
  // finished any silence refill, so that registers may be written safely.
  task automatic wait_idle();
    while (pending_items.size() > 0 || expected_results.size() > 0 || start)
      @(posedge clk);
    while (busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic in_item_t make_item(logic [1:0] kind, logic [31:0] d);
    in_item_t it;
    it.req_type = kind;
    it.data_in = d;
    return it;
  endfunction

  // Random traffic: mostly user and DMA words in a balanced mix so that the
  // ring keeps cycling, with some status requests and a few unused codes.
  task automatic queue_random(int count);
    int          pick;
    logic [1:0]  kind;
    logic [31:0] d;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 46) kind = REQ_USER;
      else if (pick < 92) kind = REQ_DMA;
      else if (pick < 98) kind = REQ_STATUS;
      else kind = 2'd3;
      pick = $urandom_range(15);
      d = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
      add_pending(make_item(kind, d));
    end
  endtask

  initial begin
    ring_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Disabled ring: user and DMA refused, status always answered, the
    // unused request code ignored.
    sender_idle_pct = 19;
    add_pending(make_item(REQ_USER, 32'hFFFF_FFFF));
    add_pending(make_item(REQ_DMA, 32'h0));
    add_pending(make_item(REQ_STATUS, 32'h1234_5678));
    add_pending(make_item(2'd3, 32'hFFFF_FFFF));
    wait_idle();

    // Small playback ring. Directed part: the first user word picks its
    // buffer, fills run into refusals, DMA plays words, completes buffers
    // and underflows, and a status read clears the sticky flag.
    set_ring(1'b1, 32'hA5A5_5A5A, 4'd3, 9'd2, 1'b1);
    for (int i = 0; i < 4; i++)
      add_pending(make_item(REQ_USER, i[0] ? 32'hFFFF_FFFF : 32'h0));
    for (int i = 0; i < 7; i++) add_pending(make_item(REQ_DMA, $urandom));
    add_pending(make_item(REQ_STATUS, 32'h0));
    add_pending(make_item(REQ_STATUS, 32'h0));
    for (int i = 0; i < 3; i++) add_pending(make_item(REQ_USER, $urandom));
    add_pending(make_item(2'd3, 32'h0));
    queue_random(430);
    wait_idle();

    // Capture with the smallest ring; reads refused until a buffer is full.
    sender_idle_pct = 67;
    set_ring(1'b0, 32'h0, 4'd2, 9'd1, 1'b1);
    add_pending(make_item(REQ_USER, 32'h0));
    add_pending(make_item(REQ_DMA, 32'hFFFF_FFFF));
    add_pending(make_item(REQ_USER, 32'h0));
    queue_random(400);
    wait_idle();

    // Capture at four buffers of five words.
    set_ring(1'b0, 32'hFFFF_FFFF, 4'd4, 9'd5, 1'b1);
    queue_random(300);
    wait_idle();

    // Largest ring in playback with an all-ones silence word; one buffer
    // completes only every 256 DMA words, so this stretch is short.
    sender_idle_pct = 0;
    set_ring(1'b1, 32'hFFFF_FFFF, 4'd8, 9'd256, 1'b1);
    queue_random(300);
    wait_idle();

    // Out-of-range sizes clamp to two buffers of one word.
    set_ring(1'b1, 32'h0000_0001, 4'd0, 9'd0, 1'b1);
    queue_random(200);
    wait_idle();

    // Sizes above the limits clamp to the maximum; then the ring shrinks
    // while running so that pointers beyond the new size wrap.
    set_ring(1'b0, 32'h0, 4'd15, 9'd511, 1'b1);
    queue_random(100);
    wait_idle();
    write_reg(REG_BCOUNT, 32'd2);
    write_reg(REG_WPB, 32'd3);
    queue_random(150);
    wait_idle();

    // Disabled again after activity: everything but status refused.
    write_reg(REG_ENABLED, 32'd0);
    queue_random(40);
    wait_idle();

    repeat (20) @(posedge clk);
    $display("Covered %0d items and %0d results across playback, capture, clamped",
             items_accepted, results_seen);
    $display("and disabled settings: %0d buffers completed, %0d accesses refused.",
             buffers_completed, refusals_seen);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
